/* hw/rtl/cbr_pkg.sv */
package cbr_pkg;

    localparam int COORD_BITS = 12;
    localparam int IN_W       = 12;
    localparam int CFG_W      = 11;
    localparam int REL_W      = 12;
    localparam int BEAR_W     = 9;
    localparam int DIST_W     = 11;

    // magnitude, signed offset, squared distance, root and remainder widths
    localparam int AW   = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;
    localparam int XW   = AW + 1;
    localparam int D2W  = 2 * AW + 1;
    localparam int RW   = AW + 1;
    localparam int REMW = RW + 2;

    // bearing search: count of whole degrees 0..89, one bit per stage
    localparam int CNT_W  = 7;
    localparam int MAX_K  = 89;
    localparam int TAB_N  = 1 << CNT_W;
    localparam int FB     = 48;
    localparam int TW     = FB + 6;
    localparam int CW     = AW + TW;

    localparam logic [1:0] CFG_CENTER_X = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [1:0] CFG_RADIUS   = 2'd2;

    localparam logic [BEAR_W-1:0] DEG_0   = BEAR_W'(0);
    localparam logic [BEAR_W-1:0] DEG_90  = BEAR_W'(90);
    localparam logic [BEAR_W-1:0] DEG_180 = BEAR_W'(180);
    localparam logic [BEAR_W-1:0] DEG_270 = BEAR_W'(270);
    localparam logic [BEAR_W-1:0] DEG_360 = BEAR_W'(360);

    typedef logic [TW-1:0] t_tan_tab [TAB_N];

    // tan(k degrees) with FB fraction bits; 45 degrees is exactly one
    function automatic t_tan_tab build_tan_tab();
        t_tan_tab tab;
        real      r;
        for (int k = 0; k < TAB_N; k++) begin
            if (k == 45) begin
                tab[k] = TW'(1) << FB;
            end else if (k > MAX_K) begin
                tab[k] = '1;
            end else begin
                r      = $tan(real'(k) * 3.14159265358979323846 / 180.0) * (2.0 ** FB);
                tab[k] = TW'(longint'(r));
            end
        end
        return tab;
    endfunction

    localparam t_tan_tab TAN_TAB = build_tan_tab();

    typedef struct packed {
        logic [CFG_W-1:0] center_x;
        logic [CFG_W-1:0] center_y;
        logic [CFG_W-1:0] radius;
    } t_cfg;

    typedef struct packed {
        logic                 vld;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [AW-1:0]        ax;
        logic [AW-1:0]        ay;
        logic [D2W-1:0]       d2;
        logic [CNT_W-1:0]     cnt;
    } t_item;

    typedef struct packed {
        t_item            it;
        logic [REMW-1:0]  rem;
        logic [RW-1:0]    root;
    } t_sq;

endpackage

/* hw/rtl/cbr_in_if.sv */
interface cbr_in_if;
    logic                      valid;
    logic                      ready;
    logic [cbr_pkg::IN_W-1:0]  pos_x;
    logic [cbr_pkg::IN_W-1:0]  pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

/* hw/rtl/cbr_cfg_if.sv */
interface cbr_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                index;
    logic [cbr_pkg::CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/cbr_out_if.sv */
interface cbr_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [cbr_pkg::REL_W-1:0]  rel_x;
    logic signed [cbr_pkg::REL_W-1:0]  rel_y;
    logic [cbr_pkg::BEAR_W-1:0]        bearing_deg;
    logic [cbr_pkg::DIST_W-1:0]        distance;

    modport source (output valid, output rel_x, output rel_y, output bearing_deg,
                    output distance, input ready);
    modport sink   (input valid, input rel_x, input rel_y, input bearing_deg,
                    input distance, output ready);
endinterface

/* hw/rtl/cbr_front.sv */
module cbr_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_vld,
    input  logic [cbr_pkg::IN_W-1:0] i_pos_x,
    input  logic [cbr_pkg::IN_W-1:0] i_pos_y,
    input  cbr_pkg::t_cfg            i_cfg,
    output cbr_pkg::t_item           o_item
);

    localparam logic [cbr_pkg::IN_W-1:0] CMASK = cbr_pkg::IN_W'((1 << cbr_pkg::COORD_BITS) - 1);

    cbr_pkg::t_item r_s1, n_s1, r_s2, n_s2;

    logic [cbr_pkg::AW-1:0]      px, py;
    logic [2*cbr_pkg::AW-1:0]    sqx, sqy;
    logic [2*cbr_pkg::CFG_W-1:0] r2;

    always_comb begin
        px        = cbr_pkg::AW'(i_pos_x & CMASK);
        py        = cbr_pkg::AW'(i_pos_y & CMASK);
        n_s1      = '0;
        n_s1.vld  = i_vld;
        n_s1.x    = $signed({1'b0, px}) - $signed(cbr_pkg::XW'(i_cfg.center_x));
        n_s1.y    = $signed(cbr_pkg::XW'(i_cfg.center_y)) - $signed({1'b0, py});
    end

    always_comb begin
        n_s2    = r_s1;
        n_s2.ax = r_s1.x[cbr_pkg::XW-1] ? cbr_pkg::AW'(-r_s1.x) : cbr_pkg::AW'(r_s1.x);
        n_s2.ay = r_s1.y[cbr_pkg::XW-1] ? cbr_pkg::AW'(-r_s1.y) : cbr_pkg::AW'(r_s1.y);
        sqx     = n_s2.ax * n_s2.ax;
        sqy     = n_s2.ay * n_s2.ay;
        r2      = i_cfg.radius * i_cfg.radius;
        n_s2.d2 = cbr_pkg::D2W'(sqx) + cbr_pkg::D2W'(sqy);
        // drop points outside the circle here
        n_s2.vld = r_s1.vld && (n_s2.d2 <= cbr_pkg::D2W'(r2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
        end else if (i_adv) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    assign o_item = r_s2;

endmodule

/* hw/rtl/cbr_atan.sv */
module cbr_atan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  cbr_pkg::t_item i_item,
    output cbr_pkg::t_item o_item
);

    cbr_pkg::t_item r_st [cbr_pkg::CNT_W];

    for (genvar s = 0; s < cbr_pkg::CNT_W; s++) begin : g_step
        cbr_pkg::t_item              src, n_st;
        logic [cbr_pkg::CNT_W-1:0]   cand;
        logic [cbr_pkg::CW-1:0]      lhs, prod;

        if (s == 0) begin : g_first
            assign src = i_item;
        end else begin : g_next
            assign src = r_st[s-1];
        end

        // try the next bit of the degree count: keep it if cand <= MAX_K and ay >= ax*tan(cand)
        always_comb begin
            n_st = src;
            if (s == 0) begin
                n_st.cnt = '0;
            end
            cand = n_st.cnt | cbr_pkg::CNT_W'(1 << (cbr_pkg::CNT_W - 1 - s));
            lhs  = cbr_pkg::CW'(src.ay) << cbr_pkg::FB;
            prod = src.ax * cbr_pkg::TAN_TAB[cand];
            if ((cand <= cbr_pkg::CNT_W'(cbr_pkg::MAX_K)) && (lhs >= prod)) begin
                n_st.cnt = cand;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[s].vld <= 1'b0;
            end else if (i_adv) begin
                r_st[s] <= n_st;
            end
        end
    end

    assign o_item = r_st[cbr_pkg::CNT_W-1];

endmodule

/* hw/rtl/cbr_isqrt.sv */
module cbr_isqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  cbr_pkg::t_item i_item,
    output cbr_pkg::t_sq   o_sq
);

    cbr_pkg::t_sq r_st [cbr_pkg::RW];

    for (genvar s = 0; s < cbr_pkg::RW; s++) begin : g_step
        localparam int BI = cbr_pkg::RW - 1 - s;

        cbr_pkg::t_sq                src, n_st;
        logic [2*cbr_pkg::RW-1:0]    d2p;
        logic [cbr_pkg::REMW+1:0]    cand, trial;

        if (s == 0) begin : g_first
            always_comb begin
                src    = '0;
                src.it = i_item;
            end
        end else begin : g_next
            assign src = r_st[s-1];
        end

        // one root bit per stage, restoring
        always_comb begin
            n_st  = src;
            d2p   = (2*cbr_pkg::RW)'(src.it.d2);
            cand  = {src.rem, d2p[2*BI+1 -: 2]};
            trial = (cbr_pkg::REMW+2)'({src.root, 2'b01});
            if (cand >= trial) begin
                n_st.rem  = cbr_pkg::REMW'(cand - trial);
                n_st.root = {src.root[cbr_pkg::RW-2:0], 1'b1};
            end else begin
                n_st.rem  = cbr_pkg::REMW'(cand);
                n_st.root = {src.root[cbr_pkg::RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[s].it.vld <= 1'b0;
            end else if (i_adv) begin
                r_st[s] <= n_st;
            end
        end
    end

    assign o_sq = r_st[cbr_pkg::RW-1];

endmodule

/* hw/rtl/cartesian_to_bearing_range.sv */
// Cartesian to bearing/range converter for a circular display.
// i_in carries scene points (pos_x, pos_y, y downward); o_out carries the
// offset from the display centre (y upward), the bearing in whole degrees and
// the floor of the distance. Points outside the configured circle give no
// transfer on o_out. i_cfg writes centre_x, centre_y and radius by index;
// it is always ready and an unknown index is dropped.
// Throughput: one point per cycle while the receiver does not stall. The
// pipeline has 2 offset/square stages, 7 bearing search stages of one
// multiply and compare each, 13 square-root stages of one bit each and one
// output register.
// Reset clears the configuration and all valid bits to zero and empties the pipeline.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and i_in.ready falls; nothing is lost or repeated. Bubbles and dropped
// points keep advancing while the output register is empty.
module cartesian_to_bearing_range (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cbr_in_if.sink         i_in,
    cbr_cfg_if.sink        i_cfg,
    cbr_out_if.source      o_out
);

    cbr_pkg::t_cfg  r_cfg;
    cbr_pkg::t_item front_item, atan_item;
    cbr_pkg::t_sq   sq;

    logic                           adv;
    logic                           r_out_vld;
    logic signed [cbr_pkg::REL_W-1:0] r_rel_x, r_rel_y;
    logic [cbr_pkg::BEAR_W-1:0]     r_bearing, n_bearing;
    logic [cbr_pkg::DIST_W-1:0]     r_distance;
    logic [cbr_pkg::BEAR_W-1:0]     cnt_ext;
    logic                           x_zero, y_zero, x_neg, y_neg;

    // advance the whole pipeline unless a result waits on a stalled receiver
    assign adv         = !r_out_vld || o_out.ready;
    assign i_in.ready  = adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                cbr_pkg::CFG_CENTER_X: r_cfg.center_x <= i_cfg.data;
                cbr_pkg::CFG_CENTER_Y: r_cfg.center_y <= i_cfg.data;
                cbr_pkg::CFG_RADIUS:   r_cfg.radius   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    cbr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (i_in.valid),
        .i_pos_x (i_in.pos_x),
        .i_pos_y (i_in.pos_y),
        .i_cfg   (r_cfg),
        .o_item  (front_item)
    );

    cbr_atan u_atan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (front_item),
        .o_item  (atan_item)
    );

    cbr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (atan_item),
        .o_sq    (sq)
    );

    // quadrant correction of the first-quadrant degree count
    always_comb begin
        cnt_ext = cbr_pkg::BEAR_W'(sq.it.cnt);
        x_zero  = (sq.it.x == '0);
        y_zero  = (sq.it.y == '0);
        x_neg   = sq.it.x[cbr_pkg::XW-1];
        y_neg   = sq.it.y[cbr_pkg::XW-1];
        if (x_zero) begin
            n_bearing = (!y_neg && !y_zero) ? cbr_pkg::DEG_90 : cbr_pkg::DEG_270;
        end else if (y_zero) begin
            n_bearing = x_neg ? cbr_pkg::DEG_180 : cbr_pkg::DEG_0;
        end else if (!x_neg && !y_neg) begin
            n_bearing = cnt_ext;
        end else if (x_neg && !y_neg) begin
            n_bearing = cbr_pkg::DEG_180 - cnt_ext;
        end else if (x_neg) begin
            n_bearing = cbr_pkg::DEG_180 + cnt_ext;
        end else if (cnt_ext == '0) begin
            // wrap a full turn back to zero
            n_bearing = cbr_pkg::DEG_0;
        end else begin
            n_bearing = cbr_pkg::DEG_360 - cnt_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld  <= sq.it.vld;
            r_rel_x    <= cbr_pkg::REL_W'(sq.it.x);
            r_rel_y    <= cbr_pkg::REL_W'(sq.it.y);
            r_bearing  <= n_bearing;
            r_distance <= cbr_pkg::DIST_W'(sq.root);
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.rel_x       = r_rel_x;
    assign o_out.rel_y       = r_rel_y;
    assign o_out.bearing_deg = r_bearing;
    assign o_out.distance    = r_distance;

endmodule

/* tb/cartesian_to_bearing_range_tb.sv */
`timescale 1ns / 100ps

module cartesian_to_bearing_range_tb;

    localparam logic [1:0] CFG_SPARE = 2'd3;   // index with no register behind it
    localparam int         DRAIN_CYCLES = 40;  // comfortably beyond the time a point takes through the pipeline

    typedef struct {
        logic signed [cbr_pkg::REL_W-1:0] rel_x;
        logic signed [cbr_pkg::REL_W-1:0] rel_y;
        logic [cbr_pkg::BEAR_W-1:0]       bearing_deg;
        logic [cbr_pkg::DIST_W-1:0]       distance;
    } t_fix;

    // Polar fix predictor and store of fixes still owed by the block.
    class polar_fix_scoreboard;
        t_fix                       owed[$];
        logic [cbr_pkg::CFG_W-1:0]  ctr_x, ctr_y, rad;
        longint unsigned            sin_q62[90];
        longint unsigned            cos_q62[90];
        int                         errors;

        function new();
            ctr_x = '0;
            ctr_y = '0;
            rad = '0;
            errors = 0;
            make_trig();
        endfunction

        function longint unsigned q62_mul(longint unsigned a, longint unsigned b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return p[125:62];
        endfunction

        // sine/cosine for whole degrees by truncated Taylor series in Q62
        function void make_trig();
            longint unsigned stp, th, term, cp, cn, sp, sn;
            stp = 64'h3243F6A8885A308D / 45;
            for (int k = 0; k < 90; k++) begin
                th = stp * k;
                term = 64'd1 << 62;
                cp = term; cn = 0; sp = 0; sn = 0;
                for (int n = 1; n <= 40; n++) begin
                    term = q62_mul(term, th) / n;
                    if (term == 0) break;
                    if (n % 2 == 1) begin
                        if (((n / 2) % 2) == 0) sp += term; else sn += term;
                    end else begin
                        if (((n / 2) % 2) == 0) cp += term; else cn += term;
                    end
                end
                sin_q62[k] = (sp >= sn) ? sp - sn : 0;
                cos_q62[k] = (cp >= cn) ? cp - cn : 0;
            end
            cos_q62[45] = sin_q62[45];
        endfunction

        function void set_reg(logic [1:0] idx, logic [cbr_pkg::CFG_W-1:0] val);
            case (idx)
                cbr_pkg::CFG_CENTER_X: ctr_x = val;
                cbr_pkg::CFG_CENTER_Y: ctr_y = val;
                cbr_pkg::CFG_RADIUS:   rad = val;
                default: ;
            endcase
        endfunction

        // largest whole degree k with ay*cos(k) >= ax*sin(k)
        function int whole_angle(longint unsigned ax, longint unsigned ay);
            logic [127:0] lhs, rhs;
            int cnt;
            cnt = 0;
            for (int k = 1; k < 90; k++) begin
                lhs = {64'd0, ay} * {64'd0, cos_q62[k]};
                rhs = {64'd0, ax} * {64'd0, sin_q62[k]};
                if (lhs < rhs) break;
                cnt = k;
            end
            return cnt;
        endfunction

        function longint unsigned floor_root(longint unsigned v);
            longint unsigned r;
            r = 0;
            while ((r + 1) * (r + 1) <= v) r++;
            return r;
        endfunction

        function void note_point(logic [cbr_pkg::IN_W-1:0] px, logic [cbr_pkg::IN_W-1:0] py);
            longint x, y, ax, ay;
            longint unsigned d2;
            int k, brg;
            t_fix f;
            x = longint'(px) - longint'(ctr_x);
            y = longint'(ctr_y) - longint'(py);
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            d2 = ax * ax + ay * ay;
            if (d2 > longint'(rad) * longint'(rad)) return;  // outside: nothing owed
            if (x == 0) begin
                brg = (y > 0) ? 90 : 270;
            end else begin
                k = whole_angle(ax, ay);
                if (y == 0) brg = (x < 0) ? 180 : 0;
                else if (x > 0 && y > 0) brg = k;
                else if (x < 0 && y > 0) brg = 180 - k;
                else if (x < 0) brg = 180 + k;
                else brg = (k == 0) ? 0 : 360 - k;
            end
            f.rel_x = x[cbr_pkg::REL_W-1:0];
            f.rel_y = y[cbr_pkg::REL_W-1:0];
            f.bearing_deg = brg[cbr_pkg::BEAR_W-1:0];
            f.distance = cbr_pkg::DIST_W'(floor_root(d2));
            owed.push_back(f);
        endfunction

        function void check_fix(t_fix got);
            t_fix exp_f;
            if (owed.size() == 0) begin
                $error("unexpected fix rel_x=%0d rel_y=%0d", got.rel_x, got.rel_y);
                errors++;
                return;
            end
            exp_f = owed.pop_front();
            if (got.rel_x !== exp_f.rel_x) begin
                $error("rel_x expected %0d actual %0d", exp_f.rel_x, got.rel_x);
                errors++;
            end
            if (got.rel_y !== exp_f.rel_y) begin
                $error("rel_y expected %0d actual %0d", exp_f.rel_y, got.rel_y);
                errors++;
            end
            if (got.bearing_deg !== exp_f.bearing_deg) begin
                $error("bearing_deg expected %0d actual %0d", exp_f.bearing_deg,
                       got.bearing_deg);
                errors++;
            end
            if (got.distance !== exp_f.distance) begin
                $error("distance expected %0d actual %0d", exp_f.distance, got.distance);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    cbr_in_if  pts ();
    cbr_cfg_if cfg ();
    cbr_out_if fix ();

    cartesian_to_bearing_range dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (pts.sink),
        .i_cfg  (cfg.sink),
        .o_out  (fix.source)
    );

    polar_fix_scoreboard sb = new();
    bit calm;   // when set, neither side idles

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Pick an idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Register write; callers must make it only while the block is idle, which the block does not enforce.
    task automatic write_reg(logic [1:0] idx, logic [cbr_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge i_clk); while (!cfg.ready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    // Offer one point; hold valid until the transfer, then idle for a picked gap, possibly none.
    task automatic send_point(logic [cbr_pkg::IN_W-1:0] px, logic [cbr_pkg::IN_W-1:0] py);
        int gap;
        @(negedge i_clk);
        pts.valid <= 1'b1;
        pts.pos_x <= px;
        pts.pos_y <= py;
        do @(posedge i_clk); while (!pts.ready);
        sb.note_point(px, py);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            pts.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drop valid, wait for every owed fix, then let dropped points clear the pipe.
    task automatic settle();
        @(negedge i_clk);
        pts.valid <= 1'b0;
        while (sb.owed.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_display(int cx, int cy, int r);
        settle();
        write_reg(cbr_pkg::CFG_CENTER_X, cbr_pkg::CFG_W'(cx));
        write_reg(cbr_pkg::CFG_CENTER_Y, cbr_pkg::CFG_W'(cy));
        write_reg(cbr_pkg::CFG_RADIUS, cbr_pkg::CFG_W'(r));
    endtask

    // Offset relative to the current centre, wrapped into the scene field.
    task automatic send_offset(int dx, int dy);
        send_point(cbr_pkg::IN_W'(int'(sb.ctr_x) + dx), cbr_pkg::IN_W'(int'(sb.ctr_y) - dy));
    endtask

    // Mostly points in the square around the circle, some anywhere in the scene.
    task automatic random_points(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            if (i % 150 == 0) calm = ($urandom_range(0, 3) == 0);
            r = int'(sb.rad);
            if ($urandom_range(0, 9) < 7) begin
                send_offset($urandom_range(0, 2 * r) - r, $urandom_range(0, 2 * r) - r);
            end else begin
                send_point(cbr_pkg::IN_W'($urandom), cbr_pkg::IN_W'($urandom));
            end
        end
        calm = 1'b0;
    endtask

    // Receiver: random stalls, mostly short, with stall-free stretches.
    initial begin
        int stall;
        fix.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = pick_gap();
            if (stall == 0) begin
                fix.ready <= 1'b1;
            end else begin
                fix.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    // Check each fix transfer at the edge that takes it.
    always @(posedge i_clk) begin
        t_fix got;
        if (i_rst_n && fix.valid && fix.ready) begin
            got.rel_x = fix.rel_x;
            got.rel_y = fix.rel_y;
            got.bearing_deg = fix.bearing_deg;
            got.distance = fix.distance;
            sb.check_fix(got);
        end
    end

    initial begin
        pts.valid = 1'b0;
        pts.pos_x = '0;
        pts.pos_y = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data  = '0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values: zero radius, only the centre point itself hits
        send_point(12'd0, 12'd0);
        send_point(12'd1, 12'd0);
        send_point(12'hFFF, 12'hFFF);

        // directed: axes, diagonals, near-vertical, near-horizontal and far corners
        set_display(1024, 1024, 2047);
        write_reg(CFG_SPARE, 11'h7FF);      // unknown index: drop it
        send_offset(0, 0);
        send_offset(100, 0);
        send_offset(-100, 0);
        send_offset(0, 100);
        send_offset(0, -100);
        send_offset(37, 37);
        send_offset(-37, 37);
        send_offset(-37, -37);
        send_offset(37, -37);
        send_offset(1, 1000);
        send_offset(1, -1000);
        send_offset(1000, -1);
        send_offset(-1000, 1);
        send_offset(1023, 1023);
        send_point(12'd0, 12'd0);
        send_point(12'hFFF, 12'hFFF);
        send_point(12'd2047, 12'd0);

        // full extremes of the registers
        set_display(2047, 2047, 2047);
        send_point(12'd4094, 12'd2047);
        send_point(12'd2047, 12'd0);
        send_point(12'd0, 12'd2047);
        random_points(200);

        set_display(0, 0, 2047);
        random_points(200);

        set_display(0, 2047, 2047);
        random_points(200);

        set_display(1000, 1000, 0);
        send_offset(0, 0);
        send_offset(1, 0);
        random_points(60);

        set_display(700, 500, 300);
        random_points(250);

        set_display(1500, 300, 5);
        random_points(150);

        for (int p = 0; p < 3; p++) begin
            set_display($urandom_range(0, 2047), $urandom_range(0, 2047),
                        $urandom_range(0, 2047));
            random_points(130);
        end

        settle();
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Guard: well beyond the slowest legal run.
    initial begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/cbr_pkg.sv
hw/rtl/cbr_in_if.sv
hw/rtl/cbr_cfg_if.sv
hw/rtl/cbr_out_if.sv
hw/rtl/cbr_front.sv
hw/rtl/cbr_atan.sv
hw/rtl/cbr_isqrt.sv
hw/rtl/cartesian_to_bearing_range.sv
tb/cartesian_to_bearing_range_tb.sv
